// ----- sv/dsff_pkg.sv -----
// shared types, constants and the decimal denominator table
`timescale 1ns / 1ps
package dsff_pkg;

  localparam int FRACTION_BITS_DEF = 32;
  localparam int MAX_FRACTION_DIGITS_DEF = 9;
  localparam int WHOLE_W = 31;
  localparam int FRAC_VAL_W = 30;
  localparam int DIGITS_W = 4;
  localparam int MANT_W = 23;
  localparam int EXP_W = 8;
  localparam int EXP_BIAS = 127;

  typedef struct packed {
    logic                  sign_in;
    logic [WHOLE_W-1:0]    whole_part;
    logic [FRAC_VAL_W-1:0] fraction_value;
    logic [DIGITS_W-1:0]   fraction_digits;
  } in_item_t;

  typedef struct packed {
    logic              sign_out;
    logic [EXP_W-1:0]  biased_exponent;
    logic [MANT_W-1:0] mantissa;
    logic              is_zero;
    logic              bad_input;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // ten to the digit count, zero for counts past the table
  function automatic logic [63:0] pow10(input logic [DIGITS_W-1:0] digits);
    logic [63:0] val;
    case (digits)
      4'd0:    val = 64'd1;
      4'd1:    val = 64'd10;
      4'd2:    val = 64'd100;
      4'd3:    val = 64'd1000;
      4'd4:    val = 64'd10000;
      4'd5:    val = 64'd100000;
      4'd6:    val = 64'd1000000;
      4'd7:    val = 64'd10000000;
      4'd8:    val = 64'd100000000;
      4'd9:    val = 64'd1000000000;
      default: val = 64'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/dsff_frac_div.sv -----
// restoring divider producing binary fraction bits one per cycle
`timescale 1ns / 1ps
module dsff_frac_div
  import dsff_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int DEN_W = 30
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DEN_W-1:0]         numer_i,
  input  logic [DEN_W-1:0]         denom_i,
  output div_status_t              status_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [DEN_W-1:0]         rem_q, rem_d;
  logic [DEN_W-1:0]         den_q, den_d;
  logic [FRACTION_BITS-1:0] quot_q, quot_d;
  logic [DEN_W:0]           rem2;
  logic [DEN_W:0]           diff;
  logic                     take;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign take = (rem2 >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d = CNT_W'(FRACTION_BITS);
      rem_d = numer_i;
      den_d = denom_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      rem_d  = take ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      quot_d = {quot_q[FRACTION_BITS-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("divider started while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(1)) && !start_i |=> done_q && (cnt_q == '0))
    else $error("divider done pulse missing");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q == '0))
    else $error("divider done while still counting");
`endif

endmodule

// ----- sv/decimal_to_single_float_fields.sv -----
// decimal to single-precision fields: FRACTION_BITS divide steps, then a leading-one shift
// a bad input goes straight to emit; else the one-bit-per-cycle restoring divider runs
// FRACTION_BITS steps, then the 8-or-1 bit normalize shifter runs unless the word is zero,
// and the result is emitted one beat at a time; a new beat is taken once the previous
// result is in the output register
// reset clears the sequencer and the output valid; payload registers are not reset
`timescale 1ns / 1ps
module decimal_to_single_float_fields
  import dsff_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [63:0] MAX_DEN = pow10(DIGITS_W'(MAX_FRACTION_DIGITS));
  localparam int DEN_W = $clog2(MAX_DEN + 64'd1);
  localparam int WW = WHOLE_W + FRACTION_BITS;
  localparam int SW = $clog2(WW + 1);
  localparam int EXP_TOP = EXP_BIAS + WHOLE_W - 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic                 sign_q, sign_d;
  logic [WHOLE_W-1:0]   whole_q, whole_d;
  logic [WW-1:0]        norm_q, norm_d;
  logic [SW-1:0]        shift_q, shift_d;
  out_item_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;

  logic                 in_beat;
  logic [63:0]          den_lut;
  logic                 bad;
  logic                 div_start;
  div_status_t          div_status;
  logic [FRACTION_BITS-1:0] div_quot;
  logic [9:0]           exp_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign den_lut    = pow10(in_data_i.fraction_digits);
  assign bad        = (in_data_i.fraction_digits > DIGITS_W'(MAX_FRACTION_DIGITS)) ||
                      ({1'b0, in_data_i.fraction_value} >= 31'(den_lut));
  assign div_start  = in_beat && !bad;
  assign exp_full   = 10'(EXP_TOP) - 10'(shift_q);

  dsff_frac_div #(
    .FRACTION_BITS(FRACTION_BITS),
    .DEN_W        (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (in_data_i.fraction_value[DEN_W-1:0]),
    .denom_i (den_lut[DEN_W-1:0]),
    .status_o(div_status),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    sign_d      = sign_q;
    whole_d     = whole_q;
    norm_d      = norm_q;
    shift_d     = shift_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          sign_d  = in_data_i.sign_in;
          whole_d = in_data_i.whole_part;
          if (bad) begin
            res_d           = '0;
            res_d.bad_input = 1'b1;
            state_d         = ST_EMIT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          norm_d  = {whole_q, div_quot};
          shift_d = '0;
          if ({whole_q, div_quot} == '0) begin
            res_d         = '0;
            res_d.is_zero = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (norm_q[WW-1]) begin
          res_d.sign_out        = sign_q;
          res_d.biased_exponent = exp_full[EXP_W-1:0];
          res_d.mantissa        = norm_q[WW-2 -: MANT_W];
          res_d.is_zero         = 1'b0;
          res_d.bad_input       = 1'b0;
          state_d               = ST_EMIT;
        end else if (norm_q[WW-1 -: 8] == 8'd0) begin
          norm_d  = {norm_q[WW-9:0], 8'd0};
          shift_d = shift_q + SW'(8);
        end else begin
          norm_d  = {norm_q[WW-2:0], 1'b0};
          shift_d = shift_q + SW'(1);
        end
      end
      ST_EMIT: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q     <= sign_d;
    whole_q    <= whole_d;
    norm_q     <= norm_d;
    shift_q    <= shift_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |-> (norm_q != '0))
    else $error("normalize word lost its leading one");
  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_status.busy || div_status.done))
    else $error("waiting on an idle divider");
  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |-> (shift_q < SW'(WW)))
    else $error("normalize shift ran past the word");
`endif

endmodule

// ----- verif/decimal_to_single_float_fields_test.sv -----
// self-checking testbench for the decimal to single-precision field converter
`timescale 1ns / 1ps
module decimal_to_single_float_fields_test;
  import dsff_pkg::*;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM = 1350;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    in_item_t  stim;
    logic      fixed;
    out_item_t want;
  } vector_t;

  // rows with fixed set carry a hand-computed result, the rest go through the predictor
  vector_t directed [N_DIRECTED] = '{
    '{'{1'b0, 31'd0, 30'd0, 4'd1}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b1, 1'b0}},
    '{'{1'b1, 31'd0, 30'd0, 4'd9}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b1, 1'b0}},
    '{'{1'b0, 31'd0, 30'd0, 4'd0}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b1, 1'b0}},
    '{'{1'b0, 31'd5, 30'd0, 4'd0}, 1'b1, '{1'b0, 8'd129, 23'h200000, 1'b0, 1'b0}},
    '{'{1'b0, 31'd5, 30'd1, 4'd0}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b0, 1'b1}},
    '{'{1'b1, 31'd7, 30'd10, 4'd1}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b0, 1'b1}},
    '{'{1'b1, 31'h7FFFFFFF, 30'h3FFFFFFF, 4'd9}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b0, 1'b1}},
    '{'{1'b1, 31'd123, 30'd0, 4'd10}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b0, 1'b1}},
    '{'{1'b0, 31'd1, 30'd0, 4'd15}, 1'b1, '{1'b0, 8'd0, 23'd0, 1'b0, 1'b1}},
    '{'{1'b0, 31'd1, 30'd0, 4'd1}, 1'b1, '{1'b0, 8'd127, 23'd0, 1'b0, 1'b0}},
    '{'{1'b0, 31'd0, 30'd5, 4'd1}, 1'b1, '{1'b0, 8'd126, 23'd0, 1'b0, 1'b0}},
    '{'{1'b1, 31'd0, 30'd25, 4'd2}, 1'b1, '{1'b1, 8'd125, 23'd0, 1'b0, 1'b0}},
    '{'{1'b1, 31'h7FFFFFFF, 30'd999999999, 4'd9}, 1'b1,
      '{1'b1, 8'd157, 23'h7FFFFF, 1'b0, 1'b0}},
    '{'{1'b0, 31'h00800000, 30'd5, 4'd1}, 1'b1, '{1'b0, 8'd150, 23'd0, 1'b0, 1'b0}},
    '{'{1'b0, 31'h40000000, 30'd0, 4'd3}, 1'b1, '{1'b0, 8'd157, 23'd0, 1'b0, 1'b0}},
    '{'{1'b0, 31'd0, 30'd1, 4'd9}, 1'b0, '0},
    '{'{1'b0, 31'd0, 30'd999999999, 4'd9}, 1'b0, '0},
    '{'{1'b0, 31'h007FFFFF, 30'd5, 4'd1}, 1'b0, '0},
    '{'{1'b0, 31'd3, 30'd14159, 4'd5}, 1'b0, '0},
    '{'{1'b1, 31'd0, 30'd1, 4'd1}, 1'b0, '0},
    '{'{1'b0, 31'd1, 30'd999999999, 4'd9}, 1'b0, '0},
    '{'{1'b0, 31'd0, 30'd12345678, 4'd8}, 1'b0, '0},
    '{'{1'b1, 31'd100, 30'd50, 4'd2}, 1'b0, '0},
    '{'{1'b0, 31'd0, 30'd3, 4'd7}, 1'b0, '0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  out_item_t pending_fields[$];
  int        field_mismatches = 0;
  bit        steady = 1'b0;

  always #10 clk_i = ~clk_i;

  decimal_to_single_float_fields dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic logic [63:0] ten_to(input logic [DIGITS_W-1:0] n);
    logic [63:0] acc;
    int k;
    acc = 64'd1;
    for (k = 0; k < n; k++) acc = acc * 64'd10;
    return acc;
  endfunction

  // binary fraction by long division, then normalize whole:fraction as one 63-bit value
  function automatic out_item_t convert_decimal(input in_item_t x);
    out_item_t   r;
    logic [63:0] denom;
    logic [63:0] rem;
    logic [31:0] fbits;
    logic [63:0] joined;
    logic [63:0] mant;
    int          k;
    int          lead;
    r = '0;
    if (x.fraction_digits > MAX_FRACTION_DIGITS_DEF) begin
      r.bad_input = 1'b1;
      return r;
    end
    denom = ten_to(x.fraction_digits);
    if (64'(x.fraction_value) >= denom) begin
      r.bad_input = 1'b1;
      return r;
    end
    rem = 64'(x.fraction_value);
    fbits = '0;
    for (k = 0; k < FRACTION_BITS_DEF; k++) begin
      rem = rem << 1;
      fbits = fbits << 1;
      if (rem >= denom) begin
        rem = rem - denom;
        fbits[0] = 1'b1;
      end
    end
    joined = {1'b0, x.whole_part, fbits};
    if (joined == 64'd0) begin
      r.is_zero = 1'b1;
      return r;
    end
    lead = 0;
    for (k = 62; k >= 0; k--) begin
      if (joined[k] && lead == 0) lead = k;
    end
    if (joined == 64'd1) lead = 0;
    if (lead >= MANT_W) mant = joined >> (lead - MANT_W);
    else mant = joined << (MANT_W - lead);
    r.sign_out = x.sign_in;
    r.biased_exponent = EXP_W'(EXP_BIAS + lead - FRACTION_BITS_DEF);
    r.mantissa = mant[MANT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t random_decimal();
    in_item_t    x;
    int          pick;
    int          width;
    logic [31:0] bits;
    logic [63:0] denom;
    pick = $urandom_range(0, 99);
    x.sign_in = 1'($urandom_range(0, 1));
    x.whole_part = 31'($urandom);
    if (pick < 18) begin
      // raw noise, mostly out-of-range fractions or digit counts
      x.fraction_value = 30'($urandom);
      x.fraction_digits = 4'($urandom);
      return x;
    end
    x.fraction_digits = (pick < 26) ? 4'd0 : 4'($urandom_range(1, MAX_FRACTION_DIGITS_DEF));
    denom = ten_to(x.fraction_digits);
    if (pick < 23) begin
      // fraction exactly at the denominator
      x.fraction_value = 30'(denom);
      return x;
    end
    case ($urandom_range(0, 9))
      0:       x.fraction_value = '0;
      1:       x.fraction_value = 30'(denom - 64'd1);
      default: x.fraction_value = 30'(64'($urandom) % denom);
    endcase
    // spread the leading one over every position of the whole part
    width = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 31);
    bits = $urandom;
    if (width == 0) x.whole_part = '0;
    else x.whole_part = 31'((bits & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1)));
    return x;
  endfunction

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input in_item_t x, input out_item_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    pending_fields.push_back(want);
  endtask

  initial begin : stimulus
    in_item_t x;
    int       i;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < N_DIRECTED; i++) begin
      x = directed[i].stim;
      send_beat(x, directed[i].fixed ? directed[i].want : convert_decimal(x));
    end
    for (i = 0; i < N_RANDOM; i++) begin
      steady = ((i / 150) % 4) == 3;
      x = random_decimal();
      send_beat(x, convert_decimal(x));
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (field_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver stalls: short bursts, occasional long holds, free-running in steady stretches
  initial begin : result_stalls
    int r;
    int n;
    forever begin
      if (steady) begin
        out_ready_i <= 1'b1;
        n = 8;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(1, 6);
        end else if (r < 90) begin
          out_ready_i <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          n = $urandom_range(10, 50);
        end
      end
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_fields.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data_o);
        field_mismatches++;
      end else begin
        want = pending_fields.pop_front();
        if (out_data_o.sign_out !== want.sign_out) begin
          $error("sign_out: expected %0d, got %0d", want.sign_out, out_data_o.sign_out);
          field_mismatches++;
        end
        if (out_data_o.biased_exponent !== want.biased_exponent) begin
          $error("biased_exponent: expected %0d, got %0d",
                 want.biased_exponent, out_data_o.biased_exponent);
          field_mismatches++;
        end
        if (out_data_o.mantissa !== want.mantissa) begin
          $error("mantissa: expected %h, got %h", want.mantissa, out_data_o.mantissa);
          field_mismatches++;
        end
        if (out_data_o.is_zero !== want.is_zero) begin
          $error("is_zero: expected %0d, got %0d", want.is_zero, out_data_o.is_zero);
          field_mismatches++;
        end
        if (out_data_o.bad_input !== want.bad_input) begin
          $error("bad_input: expected %0d, got %0d", want.bad_input, out_data_o.bad_input);
          field_mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
